@@ rtl/core/bounded_deque_with_insert_top_defines.svh @@
// assertion macros used by the deque datapath
`ifndef BOUNDED_DEQUE_WITH_INSERT_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INSERT_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/bdq_pkg.sv @@
package bdq_pkg;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_INSERT     = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_POP_BACK   = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [4:0]         position;
      logic signed [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_out;
      logic [4:0]         count_now;
   } rsp_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_POP,
      CTL_MOVE_RD,
      CTL_MOVE_WR,
      CTL_INS_WR
   } ctl_state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_REPLY,
      DP_PUSH_FRONT,
      DP_PUSH_BACK,
      DP_POP_READ,
      DP_POP_DONE,
      DP_MOVE_INIT,
      DP_MOVE_RD,
      DP_MOVE_WR,
      DP_INSERT
   } dp_op_type;

   // what the latched word turns into once decoded
   typedef enum logic [2:0] {
      CLS_REPLY,
      CLS_PUSH_FRONT,
      CLS_PUSH_BACK,
      CLS_POP,
      CLS_INSERT
   } cls_type;

   typedef struct packed {
      logic      load;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    move_last;
   } dp_stat_type;

endpackage

@@ rtl/core/bdq_ctrl.sv @@
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      dp_cmd.load = 1'b0;
      dp_cmd.op   = DP_NONE;
      busy        = 1'b1;
      case (state_ff)
         CTL_IDLE: begin
            busy = 1'b0;
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in    = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            case (dp_stat.cls)
               CLS_PUSH_FRONT: begin
                  dp_cmd.op = DP_PUSH_FRONT;
                  state_in  = CTL_IDLE;
               end
               CLS_PUSH_BACK: begin
                  dp_cmd.op = DP_PUSH_BACK;
                  state_in  = CTL_IDLE;
               end
               CLS_POP: begin
                  dp_cmd.op = DP_POP_READ;
                  state_in  = CTL_POP;
               end
               CLS_INSERT: begin
                  dp_cmd.op = DP_MOVE_INIT;
                  state_in  = CTL_MOVE_RD;
               end
               default: begin
                  dp_cmd.op = DP_REPLY;
                  state_in  = CTL_IDLE;
               end
            endcase
         end
         CTL_POP: begin
            dp_cmd.op = DP_POP_DONE;
            state_in  = CTL_IDLE;
         end
         CTL_MOVE_RD: begin
            dp_cmd.op = DP_MOVE_RD;
            state_in  = CTL_MOVE_WR;
         end
         CTL_MOVE_WR: begin
            dp_cmd.op = DP_MOVE_WR;
            // last word moved once the insert slot has been vacated
            state_in  = dp_stat.move_last ? CTL_INS_WR : CTL_MOVE_RD;
         end
         CTL_INS_WR: begin
            dp_cmd.op = DP_INSERT;
            state_in  = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/bdq_datapath.sv @@
`include "bounded_deque_with_insert_top_defines.svh"

module bdq_datapath
   import bdq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  dp_cmd,
   output dp_stat_type dp_stat,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = ((CW > 5) ? CW : 5) + 1;
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   // circular store: physical slot = head + logical index, wrapped once
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] lg);
      logic [AW:0] s;
      s = {1'b0, head} + {1'b0, lg};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   logic [31:0]   mem [DEPTH];

   req_type       req_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] mv_ff, mv_in;
   logic [31:0]   rd_data_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          we, re;
   logic [AW-1:0] waddr, raddr;
   logic [31:0]   wdata;

   logic [1:0]    dec_status;
   logic [4:0]    pos_m1;
   logic [AW-1:0] p0_lg, cnt_lg, cnt_m1_lg, head_dec, head_inc;
   logic          is_full, is_empty, bad_pos, at_end;

   assign pos_m1    = req_ff.position - 5'd1;
   assign p0_lg     = AW'(pos_m1);
   assign cnt_lg    = AW'(count_ff);
   assign cnt_m1_lg = AW'(count_ff - CW'(1));
   assign head_dec  = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
   assign head_inc  = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
   assign is_full   = (count_ff == FULL_CNT);
   assign is_empty  = (count_ff == '0);
   assign bad_pos   = (req_ff.position == 5'd0)
                      || (PW'(req_ff.position) > PW'(count_ff) + PW'(1));
   assign at_end    = (PW'(pos_m1) == PW'(count_ff));

   always_comb begin
      dec_status        = ST_OK;
      dp_stat.cls       = CLS_REPLY;
      dp_stat.move_last = (PW'(mv_ff) == PW'(pos_m1));
      case (req_ff.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
            if (is_full) begin
               dec_status = ST_FULL;
            end else if (req_ff.cmd == CMD_PUSH_FRONT) begin
               dp_stat.cls = CLS_PUSH_FRONT;
            end else if (req_ff.cmd == CMD_PUSH_BACK) begin
               dp_stat.cls = CLS_PUSH_BACK;
            end else if (bad_pos) begin
               dec_status = ST_BADPOS;
            end else if (at_end) begin
               // insert just past the last entry is an append
               dp_stat.cls = CLS_PUSH_BACK;
            end else begin
               dp_stat.cls = CLS_INSERT;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (is_empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dp_stat.cls = CLS_POP;
            end
         end
         default: begin
            dec_status = ST_OK;
         end
      endcase
   end

   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      mv_in            = mv_ff;
      rsp_valid_in     = 1'b0;
      rsp_in.status    = ST_OK;
      rsp_in.value_out = '0;
      rsp_in.count_now = 5'(count_ff);
      we               = 1'b0;
      waddr            = '0;
      wdata            = req_ff.value_in;
      re               = 1'b0;
      raddr            = '0;
      case (dp_cmd.op)
         DP_REPLY: begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = dec_status;
         end
         DP_PUSH_FRONT: begin
            we               = 1'b1;
            waddr            = head_dec;
            head_in          = head_dec;
            count_in         = count_ff + CW'(1);
            rsp_valid_in     = 1'b1;
            rsp_in.count_now = 5'(count_in);
         end
         DP_PUSH_BACK: begin
            we               = 1'b1;
            waddr            = phys(head_ff, cnt_lg);
            count_in         = count_ff + CW'(1);
            rsp_valid_in     = 1'b1;
            rsp_in.count_now = 5'(count_in);
         end
         DP_POP_READ: begin
            re    = 1'b1;
            raddr = (req_ff.cmd == CMD_POP_FRONT) ? head_ff : phys(head_ff, cnt_m1_lg);
         end
         DP_POP_DONE: begin
            if (req_ff.cmd == CMD_POP_FRONT) begin
               head_in = head_inc;
            end
            count_in         = count_ff - CW'(1);
            rsp_valid_in     = 1'b1;
            rsp_in.value_out = $signed(rd_data_ff);
            rsp_in.count_now = 5'(count_in);
         end
         DP_MOVE_INIT: begin
            mv_in = cnt_m1_lg;
         end
         DP_MOVE_RD: begin
            re    = 1'b1;
            raddr = phys(head_ff, mv_ff);
         end
         DP_MOVE_WR: begin
            we    = 1'b1;
            waddr = phys(head_ff, mv_ff + AW'(1));
            wdata = rd_data_ff;
            mv_in = mv_ff - AW'(1);
         end
         DP_INSERT: begin
            we               = 1'b1;
            waddr            = phys(head_ff, p0_lg);
            count_in         = count_ff + CW'(1);
            rsp_valid_in     = 1'b1;
            rsp_in.count_now = 5'(count_in);
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         req_ff <= req_data;
      end
      mv_ff  <= mv_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= FULL_CNT,
      "entry count above depth")
   `BDQ_ASSERT_NOW(a_no_grow_when_full,
      dp_cmd.op == DP_PUSH_FRONT || dp_cmd.op == DP_PUSH_BACK || dp_cmd.op == DP_INSERT,
      !is_full, "store grown while full")
   `BDQ_ASSERT_NOW(a_no_pop_when_empty,
      dp_cmd.op == DP_POP_READ || dp_cmd.op == DP_POP_DONE,
      !is_empty, "pop issued on empty store")
   `BDQ_ASSERT_NEXT(a_single_strobe, rsp_valid_ff, !rsp_valid_ff,
      "result strobe held for two cycles")

endmodule

@@ rtl/core/bounded_deque_with_insert_top.sv @@
// once a word is accepted, push and rejected commands are decoded in the execute state and answered,
// a pop reads then answers, and an insert moves m = count-position+1 >= 1 stored words up, then writes;
// busy is high and no new word is accepted until the command is done;
// the memory moves each stored word with a read, then a write
// reset clears count, head pointer, sequencer and strobe; stored words are not cleared
// the result is a one-cycle strobe: the receiver cannot stall
module bounded_deque_with_insert_top
   import bdq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   bdq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .dp_stat (dp_stat),
      .dp_cmd  (dp_cmd)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
